// ----- rtl/cpl_pkg.sv -----
// Shared types, register codes and the LCD link command table for the panel I/O block.
`timescale 1ns / 1ps
`default_nettype none
package cpl_pkg;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] ADDR_SELECT  = 3'd0;
    localparam logic [2:0] ADDR_SENSORS = 3'd1;
    localparam logic [2:0] ADDR_LEDS    = 3'd2;
    localparam logic [2:0] ADDR_CONTROL = 3'd3;
    localparam logic [2:0] ADDR_LCD     = 3'd4;

    localparam logic [3:0] MUX_STATUS   = 4'd8;
    localparam logic [3:0] MUX_BUTTONS  = 4'd8;
    localparam int         PWR_BIT      = 6;
    localparam int         LCD_CMD_MAX  = 4;

    localparam logic [3:0] LCD_ROW_LEN [LCD_CMD_MAX + 1] = '{4'd0, 4'd9, 4'd9, 4'd1, 4'd12};

    typedef struct packed {
        logic       req_type;
        logic [2:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] board_sensors;
        logic [2:0] button_bits;
        logic       battery_ok;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       button_led_row;
        logic [8:0] button_led_bits;
        logic [3:0] board_led_rows;
        logic [3:0] board_led_column;
        logic       rom_bank;
        logic       ram_bank;
        logic       power_off_pulse;
        logic       speaker_level;
        logic       lcd_write_valid;
        logic [5:0] lcd_write_addr;
        logic [3:0] lcd_write_nibble;
    } out_word_t;

    typedef struct packed {
        logic       wr_valid;
        logic [5:0] wr_addr;
        logic [3:0] wr_nibble;
        logic       ready_set;
    } lcd_res_t;

    // data nibbles that follow a command; zero for commands without data
    function automatic logic [3:0] lcd_row_limit(input logic [3:0] cmd);
        logic [3:0] lim;
        lim = 4'd0;
        if (cmd <= 4'(LCD_CMD_MAX))
        begin
            lim = LCD_ROW_LEN[cmd[2:0]];
        end
        return lim;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cpl_if.sv -----
// Valid/ready word channels for bus accesses and results.
`timescale 1ns / 1ps
`default_nettype none
interface cpl_in_if;
    logic               valid;
    logic               ready;
    cpl_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpl_out_if;
    logic               valid;
    logic               ready;
    cpl_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/chess_panel_io_and_lcd_link.sv -----
// Top level of the panel I/O gate array with its LCD nibble link.
// One bus access word in, one result word out, at one word per cycle while the
// result side keeps up. An accepted word sits in an input register, then updates
// panel and LCD link state and lands in the output register once that is free or
// being read. The input side stays ready while a result waits, as long as the
// input register can move on. cfg_wr_data sets whether the LCD ready flag shows
// on status bit 5 (reset: shown); write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module chess_panel_io_and_lcd_link (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cpl_in_if.sink      access,
    cpl_out_if.source   result,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data
);
    import cpl_pkg::*;

    logic      s1_valid_reg;
    in_word_t  s1_data_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;
    logic      advance;
    logic      lcd_en;
    lcd_res_t  lcd_res;
    out_word_t res_next;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign access.ready = !s1_valid_reg || advance;
    assign lcd_en       = advance && (s1_data_reg.req_type == REQ_WRITE)
                          && (s1_data_reg.reg_addr == ADDR_LCD);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    cpl_lcd_link u_lcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (lcd_en),
        .nibble (s1_data_reg.write_data[3:0]),
        .res    (lcd_res)
    );

    cpl_panel_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .acc         (s1_data_reg),
        .lcd         (lcd_res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (access.ready)
            begin
                s1_valid_reg <= access.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (access.ready && access.valid)
        begin
            s1_data_reg <= access.data;
        end
        if (advance)
        begin
            out_data_reg <= res_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cpl_lcd_link.sv -----
// LCD nibble link: command capture, data nibble count and segment store writes.
`timescale 1ns / 1ps
`default_nettype none
module cpl_lcd_link (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [3:0]        nibble,
    output cpl_pkg::lcd_res_t      res
);
    import cpl_pkg::*;

    logic [3:0] cmd_reg, cmd_next;
    logic [3:0] count_reg, count_next;
    logic [3:0] cmd_m1, count_m1;
    logic       seq_end;
    logic       data_nib;

    always_comb
    begin
        cmd_next = (count_reg == 4'd0) ? nibble : cmd_reg;
        cmd_m1   = cmd_reg - 4'd1;
        count_m1 = count_reg - 4'd1;
        data_nib = (count_reg != 4'd0) && (cmd_reg >= 4'd1) && (cmd_reg <= 4'(LCD_CMD_MAX));
        seq_end  = (cmd_next > 4'(LCD_CMD_MAX)) || (count_reg >= lcd_row_limit(cmd_next));
        count_next = seq_end ? 4'd0 : count_reg + 4'd1;

        res.wr_valid  = en && data_nib;
        res.wr_addr   = res.wr_valid ? {cmd_m1[1:0], count_m1} : 6'd0;
        res.wr_nibble = res.wr_valid ? nibble : 4'd0;
        res.ready_set = en && seq_end && cmd_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= 4'd0;
            count_reg <= 4'd0;
        end
        else if (en)
        begin
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cpl_panel_regs.sv -----
// Panel registers, status read mux and result word assembly.
`timescale 1ns / 1ps
`default_nettype none
module cpl_panel_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire cpl_pkg::in_word_t  acc,
    input  wire cpl_pkg::lcd_res_t  lcd,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    output cpl_pkg::out_word_t      res
);
    import cpl_pkg::*;

    logic [7:0] select_reg, select_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] led_reg, led_next;
    logic       speaker_reg, speaker_next;
    logic       lcd_ready_reg, lcd_ready_next;
    logic       visible_reg;
    logic [7:0] rd;
    logic       pwr;
    logic       wr;

    always_comb
    begin
        wr             = acc.req_type == REQ_WRITE;
        select_next    = select_reg;
        control_next   = control_reg;
        led_next       = led_reg;
        speaker_next   = speaker_reg;
        lcd_ready_next = lcd_ready_reg | lcd.ready_set;
        rd             = 8'd0;
        pwr            = 1'b0;
        if (wr)
        begin
            case (acc.reg_addr)
                ADDR_SELECT:  select_next = acc.write_data;
                ADDR_SENSORS: speaker_next = 1'b1;
                ADDR_LEDS:
                begin
                    led_next     = acc.write_data;
                    speaker_next = 1'b0;
                end
                ADDR_CONTROL:
                begin
                    control_next = acc.write_data;
                    pwr = control_reg[PWR_BIT] && !acc.write_data[PWR_BIT];
                end
                default: ;
            endcase
        end
        else
        begin
            case (acc.reg_addr)
                ADDR_SENSORS: rd = ~acc.board_sensors;
                ADDR_CONTROL:
                begin
                    if (select_reg[3:0] == MUX_STATUS)
                    begin
                        rd = {acc.battery_ok, 1'b0, visible_reg & lcd_ready_reg, 5'd0};
                        lcd_ready_next = 1'b0;
                    end
                    else if (select_reg[3:0] < MUX_BUTTONS)
                    begin
                        rd = {acc.button_bits, 5'd0};
                    end
                end
                default: ;
            endcase
        end

        res.read_data        = rd;
        res.button_led_row   = control_next[5];
        res.button_led_bits  = {~control_next[2], ~led_next};
        res.board_led_rows   = ~select_next[7:4];
        res.board_led_column = select_next[3:0];
        res.rom_bank         = control_next[0];
        res.ram_bank         = control_next[1];
        res.power_off_pulse  = pwr;
        res.speaker_level    = speaker_next;
        res.lcd_write_valid  = lcd.wr_valid;
        res.lcd_write_addr   = lcd.wr_addr;
        res.lcd_write_nibble = lcd.wr_nibble;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg    <= 8'd0;
            control_reg   <= 8'd0;
            led_reg       <= 8'd0;
            speaker_reg   <= 1'b0;
            lcd_ready_reg <= 1'b0;
        end
        else if (en)
        begin
            select_reg    <= select_next;
            control_reg   <= control_next;
            led_reg       <= led_next;
            speaker_reg   <= speaker_next;
            lcd_ready_reg <= lcd_ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            visible_reg <= cfg_wr_data;
        end
    end
endmodule
`default_nettype wire
